>>> design/ofd_pkg.sv
// Package with shared types and constants of the oscillator frequency discipline block.
`default_nettype none
package ofd_pkg;
  localparam int unsigned AccW  = 64;
  localparam int unsigned FreqW = 40;
  localparam int unsigned CntW  = 16;
  localparam logic [63:0] FreqMax = 64'd549755813887;

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegMinCnt = 2'd1;
  localparam logic [1:0] RegStep   = 2'd2;
  localparam logic [1:0] RegStart  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_DEN, ST_DIVQ, ST_DIVR, ST_ROUND, ST_CORR, ST_CDIV, ST_DONE
  } state_e;

  // Threshold table: count limit and frequency limit of each correction pair.
  function automatic logic [15:0] lim_count(input logic [2:0] i);
    case (i)
      3'd0: lim_count = 16'd22;
      3'd1: lim_count = 16'd60;
      3'd2: lim_count = 16'd180;
      3'd3: lim_count = 16'd300;
      3'd4: lim_count = 16'd1200;
      default: lim_count = 16'd3600;
    endcase
  endfunction

  function automatic logic [25:0] lim_freq(input logic [2:0] i);
    case (i)
      3'd0: lim_freq = 26'd50000000;
      3'd1: lim_freq = 26'd1000000;
      3'd2: lim_freq = 26'd100000;
      3'd3: lim_freq = 26'd10000;
      3'd4: lim_freq = 26'd9000;
      default: lim_freq = 26'd7000;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> design/ofd_in_if.sv
// Input channel interface carrying one phase-error item.
`default_nettype none
interface ofd_in_if #(parameter int PHASE_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [PHASE_WIDTH-1:0] phase_error_ps;
  logic restart_request;
  modport source (output valid, phase_error_ps, restart_request, input ready);
  modport sink (input valid, phase_error_ps, restart_request, output ready);
endinterface
`default_nettype wire

>>> design/ofd_out_if.sv
// Output channel interface carrying one result item.
`default_nettype none
interface ofd_out_if #(parameter int DAC_WIDTH = 14);
  logic valid;
  logic ready;
  logic [DAC_WIDTH-1:0] dac_out;
  logic dac_write;
  logic signed [39:0] freq_offset;
  logic [15:0] sample_count;
  modport source (output valid, dac_out, dac_write, freq_offset, sample_count, input ready);
  modport sink (input valid, dac_out, dac_write, freq_offset, sample_count, output ready);
endinterface
`default_nettype wire

>>> design/ofd_serdiv.sv
// Bit-serial restoring divider for 64-bit magnitudes, one quotient bit per cycle.
`default_nettype none
module ofd_serdiv
  import ofd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   num_i,
  input  wire logic [63:0]   den_i,
  output logic               busy_o,
  output logic [63:0]        quo_o,
  output logic [63:0]        rem_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [64:0] trial;

  // One shift and subtract step per cycle.
  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      cnt_d = 7'd64;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

>>> design/oscillator_frequency_discipline_top.sv
// Top level of the oscillator frequency discipline block.
// Usage: one input item per second carries a signed phase error in picoseconds and a
// restart flag; each item yields exactly one result item with the DAC code, a DAC
// write flag, the 40-bit fractional frequency estimate and the window sample count.
// Items are handled one at a time. The time until the result is valid depends on
// whether an estimate is formed and whether a correction follows. It is set by
// bit-serial multiplies and a serial divider that is used for the divide by six,
// the regression divide, its rounding step and the DAC step divide.
// The input is ready only in the idle state with no result waiting; the result is held
// in an output register until the receiver takes it, and the next item can be taken in
// the cycle after that. A stalled receiver stalls the input.
// Reset clears the window sums, count and estimate and loads the DAC code from the
// dac_start register default; registers return to their defaults.
// Configuration must be written through the APB port while the block is idle, which the
// block itself does not enforce; writing dac_start also reloads the DAC code.
`default_nettype none
module oscillator_frequency_discipline_top
  import ofd_pkg::*;
#(
  parameter int PHASE_WIDTH = 24,
  parameter int DAC_WIDTH   = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ofd_in_if.sink           in_if,
  ofd_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  state_e state_q, state_d;

  logic [15:0] win_q;
  logic [7:0]  minc_q;
  logic [29:0] step_q;
  logic [13:0] start_q;

  logic [15:0] cnt_q, cnt_d;
  logic [63:0] wsum_q, wsum_d, psum_q, psum_d;
  logic [63:0] freq_q, freq_d;
  logic        pend_q, pend_d;
  logic [15:0] dac_q, dac_d;
  logic        rst_win_q, rst_win_d;
  logic        wrote_q, wrote_d;

  // Serial multiplier: accumulator += multiplicand shifted when multiplier bit set.
  logic [63:0] mc_q, mc_d, mp_q, mp_d, acc_q, acc_d;
  logic [4:0]  mcnt_q, mcnt_d;
  logic [1:0]  phase_q, phase_d;
  logic [63:0] tmp_q, tmp_d, d_q, d_d, d6_q, d6_d, qq_q, qq_d;
  logic        neg_q, neg_d;
  logic [2:0]  ti_q, ti_d;
  logic        hit_q, hit_d;

  logic        div_start;
  logic [63:0] div_num, div_den, div_quo, div_rem;
  logic        div_busy;
  logic        cfg_wr;
  logic        out_valid_q, out_valid_d;

  ofd_serdiv u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo), .rem_o(div_rem)
  );

  // APB register file.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[3:2])
      RegWindow: prdata = {16'd0, win_q};
      RegMinCnt: prdata = {24'd0, minc_q};
      RegStep:   prdata = {2'd0, step_q};
      RegStart:  prdata = {18'd0, start_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= 16'd7200;
      minc_q  <= 8'd20;
      step_q  <= 30'd36600;
      start_q <= 14'd8192;
    end else if (cfg_wr && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        RegWindow: win_q   <= pwdata[15:0];
        RegMinCnt: minc_q  <= pwdata[7:0];
        RegStep:   step_q  <= pwdata[29:0];
        RegStart:  start_q <= pwdata[13:0];
        default:   ;
      endcase
    end
  end

  logic [63:0] x_ext;
  assign x_ext = {{(64-PHASE_WIDTH){in_if.phase_error_ps[PHASE_WIDTH-1]}},
                  in_if.phase_error_ps};
  assign in_if.ready = (state_q == ST_IDLE) && !out_valid_q;

  logic [63:0] mag_f;
  logic [63:0] step_ext;
  logic [63:0] d_raw;
  logic [63:0] q1000;
  assign mag_f    = freq_q[63] ? (64'd0 - freq_q) : freq_q;
  assign step_ext = (step_q == 30'd0) ? 64'd1 : {34'd0, step_q};
  assign d_raw    = (wsum_q << 1) - acc_q;
  assign q1000    = (qq_q << 10) - (qq_q << 4) - (qq_q << 3);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_if.valid && in_if.ready) state_d = ST_ACC;
      ST_ACC:   if (mcnt_q == 5'd0 && phase_q == 2'd1) begin
                  state_d = (cnt_q >= {8'd0, minc_q} && cnt_q >= 16'd2) ? ST_DEN : ST_CORR;
                end
      ST_DEN:   if (mcnt_q == 5'd0 && phase_q == 2'd3) state_d = ST_DIVQ;
      ST_DIVQ:  if (!div_busy && phase_q == 2'd1) state_d = ST_DIVR;
      ST_DIVR:  if (!div_busy && phase_q == 2'd1) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_CORR;
      ST_CORR:  if (ti_q == 3'd6) state_d = (hit_q && !rst_win_q) ? ST_CDIV : ST_DONE;
      ST_CDIV:  if (!div_busy && phase_q == 2'd1) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath sequencing.
  always_comb begin
    cnt_d = cnt_q; wsum_d = wsum_q; psum_d = psum_q; freq_d = freq_q;
    pend_d = pend_q; dac_d = dac_q; rst_win_d = rst_win_q;
    wrote_d = wrote_q; mc_d = mc_q; mp_d = mp_q; acc_d = acc_q;
    mcnt_d = mcnt_q; phase_d = phase_q; tmp_d = tmp_q; d_d = d_q; d6_d = d6_q;
    qq_d = qq_q; neg_d = neg_q; ti_d = ti_q; hit_d = hit_q;
    out_valid_d = out_valid_q;
    div_start = 1'b0; div_num = d_q; div_den = d6_q;
    if (out_valid_q && out_if.ready) out_valid_d = 1'b0;
    if (cfg_wr && paddr == {RegStart, 2'b00}) dac_d = {2'd0, pwdata[13:0]};
    case (state_q)
      ST_IDLE: if (in_if.valid && in_if.ready) begin
        rst_win_d = pend_q || in_if.restart_request;
        if (rst_win_d || cnt_q >= win_q) begin
          cnt_d = 16'd1; wsum_d = '0; psum_d = x_ext;
        end else begin
          cnt_d = cnt_q + 16'd1; psum_d = psum_q + x_ext;
        end
        mc_d = x_ext; mp_d = {48'd0, cnt_d};
        acc_d = '0; mcnt_d = 5'd16; phase_d = 2'd0; wrote_d = 1'b0; ti_d = '0;
        hit_d = 1'b0;
      end
      ST_ACC: begin
        // x * count, then (count+1) * plain_sum.
        if (mcnt_q != 5'd0) begin
          if (mp_q[0]) acc_d = acc_q + mc_q;
          mc_d = mc_q << 1; mp_d = mp_q >> 1; mcnt_d = mcnt_q - 5'd1;
        end else if (phase_q == 2'd0) begin
          wsum_d = wsum_q + acc_q;
          mc_d = psum_q; mp_d = {47'd0, {1'b0, cnt_q} + 17'd1}; acc_d = '0;
          mcnt_d = 5'd17; phase_d = 2'd1;
        end else begin
          d_d = d_raw;
          mc_d = {48'd0, cnt_q}; mp_d = {48'd0, cnt_q - 16'd1};
          acc_d = '0; mcnt_d = 5'd16; phase_d = 2'd0;
        end
      end
      ST_DEN: begin
        // n*(n-1), then *(n+1), then /6 through the divider.
        if (mcnt_q != 5'd0) begin
          if (mp_q[0]) acc_d = acc_q + mc_q;
          mc_d = mc_q << 1; mp_d = mp_q >> 1; mcnt_d = mcnt_q - 5'd1;
        end else if (phase_q == 2'd0) begin
          mc_d = acc_q; mp_d = {47'd0, {1'b0, cnt_q} + 17'd1}; acc_d = '0;
          mcnt_d = 5'd17; phase_d = 2'd1;
        end else if (phase_q == 2'd1) begin
          div_start = 1'b1; div_num = acc_q; div_den = 64'd6; phase_d = 2'd2;
        end else if (phase_q == 2'd2) begin
          if (!div_busy) phase_d = 2'd3;
        end else begin
          d6_d = div_quo; neg_d = d_q[63];
          d_d = d_q[63] ? (64'd0 - d_q) : d_q;
          phase_d = 2'd0;
        end
      end
      ST_DIVQ: begin
        if (phase_q == 2'd0) begin
          div_start = 1'b1; div_num = d_q; div_den = d6_q; phase_d = 2'd1;
        end else if (!div_busy) begin
          qq_d = div_quo;
          // remainder * 1000 + d6/2
          tmp_d = (div_rem << 10) - (div_rem << 4) - (div_rem << 3) + (d6_q >> 1);
          phase_d = 2'd0;
        end
      end
      ST_DIVR: begin
        if (phase_q == 2'd0) begin
          div_start = 1'b1; div_num = tmp_q; div_den = d6_q; phase_d = 2'd1;
        end else if (!div_busy) begin
          tmp_d = q1000 + div_quo; phase_d = 2'd0;
        end
      end
      ST_ROUND: begin
        if (neg_q)
          freq_d = (tmp_q > FreqMax + 64'd1) ? ~FreqMax : (64'd0 - tmp_q);
        else
          freq_d = (tmp_q > FreqMax) ? FreqMax : tmp_q;
      end
      ST_CORR: begin
        // One threshold pair checked per cycle.
        if (ti_q != 3'd6) begin
          if (cnt_q >= lim_count(ti_q) && mag_f >= {38'd0, lim_freq(ti_q)}) hit_d = 1'b1;
          ti_d = ti_q + 3'd1;
        end else if (rst_win_q) begin
          pend_d = 1'b0;
        end else if (hit_q) begin
          div_start = 1'b1; div_num = mag_f; div_den = step_ext; phase_d = 2'd1;
        end
      end
      ST_CDIV: if (!div_busy && phase_q == 2'd1) begin
        qq_d = ((div_rem << 2) + div_rem > step_ext) ? div_quo + 64'd1 : div_quo;
        if (freq_q[63]) dac_d = dac_q + qq_d[15:0];
        else dac_d = dac_q - qq_d[15:0];
        wrote_d = 1'b1; pend_d = 1'b1; phase_d = 2'd0;
      end
      ST_DONE: out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; wsum_q <= '0; psum_q <= '0; freq_q <= '0;
      pend_q <= 1'b0; dac_q <= 16'd8192; out_valid_q <= 1'b0; phase_q <= '0;
      mcnt_q <= '0; ti_q <= '0; hit_q <= 1'b0; rst_win_q <= 1'b0; wrote_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; wsum_q <= wsum_d; psum_q <= psum_d;
      freq_q <= freq_d; pend_q <= pend_d; dac_q <= dac_d; out_valid_q <= out_valid_d;
      phase_q <= phase_d; mcnt_q <= mcnt_d; ti_q <= ti_d; hit_q <= hit_d;
      rst_win_q <= rst_win_d; wrote_q <= wrote_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q <= mc_d; mp_q <= mp_d; acc_q <= acc_d; tmp_q <= tmp_d;
    d_q <= d_d; d6_q <= d6_d; qq_q <= qq_d; neg_q <= neg_d;
  end

  // Result register.
  assign out_if.valid        = out_valid_q;
  assign out_if.dac_out      = dac_q[DAC_WIDTH-1:0];
  assign out_if.dac_write    = wrote_q;
  assign out_if.freq_offset  = freq_q[39:0];
  assign out_if.sample_count = cnt_q;
endmodule
`default_nettype wire

>>> tb/ofd_tb_if.sv
// Testbench-side bundle of the APB configuration signals for the discipline block.
interface ofd_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  modport source (output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
  modport sink (input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

>>> tb/oscillator_frequency_discipline_top_test.sv
// Self-checking testbench of the oscillator frequency discipline block.
module oscillator_frequency_discipline_top_test;
  import ofd_pkg::*;

  // One result item of the block.
  typedef struct packed {
    logic [13:0]        dac;
    logic               wr;
    logic signed [39:0] freq;
    logic [15:0]        cnt;
  } disc_result_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic signed [23:0] phase;
    logic               restart;
    bit                 typed;
    disc_result_t       res;
  } stim_row_t;

  // One register setting of a random phase.
  typedef struct {
    logic [15:0] win;
    logic [7:0]  minc;
    logic [29:0] dstep;
    logic [13:0] dstart;
    int          n_items;
    bit          no_gaps;
    bit          hold_off;
  } phase_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ofd_in_if #(.PHASE_WIDTH(24)) in_ch ();
  ofd_out_if #(.DAC_WIDTH(14)) out_ch ();
  ofd_apb_if apb ();

  oscillator_frequency_discipline_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (apb.psel),
    .penable (apb.penable),
    .pwrite  (apb.pwrite),
    .paddr   (apb.paddr),
    .pwdata  (apb.pwdata),
    .prdata  (apb.prdata),
    .pready  (apb.pready)
  );

  // Clock with a period of 12.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the registers and the regression window.
  logic [15:0] win_len_q;
  logic [7:0]  min_cnt_q;
  logic [29:0] dac_step_q;
  logic [13:0] dac_start_q;
  logic [15:0] cnt_q;
  logic [63:0] wsum_q;
  logic [63:0] psum_q;
  logic [63:0] freq_q;
  logic        pending_q;
  logic [15:0] dac_code_q;

  disc_result_t dac_results_q[$];
  int  n_errors = 0;
  int  n_items_in = 0;
  int  n_results = 0;
  int  n_dac_writes = 0;
  int  n_restarts = 0;
  int  n_settings = 0;
  bit  typed_next = 1'b0;
  disc_result_t typed_res;
  bit  rx_gaps = 1'b1;
  bit  hold_req = 1'b0;
  bit  tx_gaps = 1'b1;
  int  quiet_cycles = 0;

  // Count threshold and frequency threshold of each correction pair.
  localparam logic [15:0] CorrCount [6] = '{16'd22, 16'd60, 16'd180, 16'd300, 16'd1200,
                                            16'd3600};
  localparam logic [63:0] CorrFreq [6] = '{64'd50000000, 64'd1000000, 64'd100000, 64'd10000,
                                           64'd9000, 64'd7000};

  task automatic reset_window_model();
    win_len_q   = 16'd7200;
    min_cnt_q   = 8'd20;
    dac_step_q  = 30'd36600;
    dac_start_q = 14'd8192;
    cnt_q       = '0;
    wsum_q      = '0;
    psum_q      = '0;
    freq_q      = '0;
    pending_q   = 1'b0;
    dac_code_q  = 16'd8192;
  endtask

  // Predicts the result of one phase-error item and advances the window.
  function automatic disc_result_t discipline_predict(logic signed [23:0] ph, logic rq);
    logic [63:0] x, n, d6, d, mag, q, r, m, fmag, dstep, c;
    logic restart, neg, hit;
    disc_result_t res;
    x = {{40{ph[23]}}, ph};
    restart = pending_q | rq;
    if (restart || cnt_q >= win_len_q) begin
      cnt_q = '0;
      wsum_q = '0;
      psum_q = '0;
    end
    cnt_q = cnt_q + 16'd1;
    wsum_q = wsum_q + x * 64'(cnt_q);
    psum_q = psum_q + x;
    // Least-squares slope, rounded half away from zero and saturated to 40 bits.
    if (cnt_q >= 16'(min_cnt_q) && cnt_q >= 16'd2) begin
      n = 64'(cnt_q);
      d6 = (n * (n - 64'd1) * (n + 64'd1)) / 64'd6;
      d = (wsum_q << 1) - (n + 64'd1) * psum_q;
      neg = d[63];
      mag = neg ? -d : d;
      q = mag / d6;
      r = mag % d6;
      m = q * 64'd1000 + (r * 64'd1000 + d6 / 64'd2) / d6;
      if (neg) freq_q = (m > FreqMax + 64'd1) ? -(FreqMax + 64'd1) : -m;
      else freq_q = (m > FreqMax) ? FreqMax : m;
    end
    res.wr = 1'b0;
    if (restart) begin
      pending_q = 1'b0;
    end else begin
      neg = freq_q[63];
      fmag = neg ? -freq_q : freq_q;
      hit = 1'b0;
      for (int i = 0; i < 6; i++) begin
        if (cnt_q >= CorrCount[i] && fmag >= CorrFreq[i]) hit = 1'b1;
      end
      // Dead-zone rounding of the DAC step count, then the DAC correction.
      if (hit) begin
        dstep = (dac_step_q == '0) ? 64'd1 : 64'(dac_step_q);
        c = fmag / dstep;
        if ((fmag % dstep) * 64'd5 > dstep) c = c + 64'd1;
        if (neg) c = -c;
        dac_code_q = dac_code_q - c[15:0];
        res.wr = 1'b1;
        pending_q = 1'b1;
      end
    end
    res.dac = dac_code_q[13:0];
    res.freq = freq_q[39:0];
    res.cnt = cnt_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0d (0x%0h), expected %0d (0x%0h) at %0t",
             what, got, got, want, want, $realtime);
    n_errors++;
  endtask

  // Register write followed by a read-back; the predictor follows the write.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    logic [31:0] want;
    @(negedge clk_i);
    apb.psel <= 1'b1;
    apb.penable <= 1'b0;
    apb.pwrite <= 1'b1;
    apb.paddr <= {idx, 2'b00};
    apb.pwdata <= value;
    @(negedge clk_i);
    apb.penable <= 1'b1;
    @(posedge clk_i);
    while (!apb.pready) @(posedge clk_i);
    case (idx)
      RegWindow: begin win_len_q = value[15:0]; want = {16'd0, value[15:0]}; end
      RegMinCnt: begin min_cnt_q = value[7:0]; want = {24'd0, value[7:0]}; end
      RegStep: begin dac_step_q = value[29:0]; want = {2'd0, value[29:0]}; end
      default: begin
        dac_start_q = value[13:0];
        dac_code_q = {2'd0, value[13:0]};
        want = {18'd0, value[13:0]};
      end
    endcase
    @(negedge clk_i);
    apb.pwrite <= 1'b0;
    apb.penable <= 1'b0;
    @(negedge clk_i);
    apb.penable <= 1'b1;
    @(posedge clk_i);
    while (!apb.pready) @(posedge clk_i);
    if (apb.prdata !== want)
      report_mismatch("register read-back", 64'(apb.prdata), 64'(want));
    @(negedge clk_i);
    apb.psel <= 1'b0;
    apb.penable <= 1'b0;
  endtask

  // Offers one item, with random gaps ahead of it, and waits until it is taken.
  task automatic send_item(logic signed [23:0] ph, logic rq, bit typed, disc_result_t res);
    if (tx_gaps) begin
      while ($urandom_range(99) < 38) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.phase_error_ps <= ph;
    in_ch.restart_request <= rq;
    typed_next = typed;
    typed_res = res;
    @(posedge clk_i);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk_i);
  endtask

  // Lets the block drain so that registers can be written while it is idle.
  task automatic drain_block();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (dac_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] clamp_phase(longint v);
    if (v > 64'sd8388607) return 24'sd8388607;
    if (v < -64'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // Random items: mostly linear phase ramps with noise, the rest raw noise.
  task automatic send_random(int n_items);
    int sent;
    int len;
    longint base, slope, noise;
    disc_result_t none;
    none = '0;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        len = $urandom_range(5, 80);
        case ($urandom_range(3))
          0: slope = longint'($urandom_range(50000, 300000));
          1: slope = longint'($urandom_range(1000, 20000));
          2: slope = longint'($urandom_range(10, 1000));
          default: slope = longint'($urandom_range(0, 20));
        endcase
        if ($urandom_range(1)) slope = -slope;
        base = longint'($urandom_range(0, 4000000)) - 64'sd2000000;
        for (int k = 0; k < len && sent < n_items; k++) begin
          noise = longint'($urandom_range(0, 200)) - 64'sd100;
          send_item(clamp_phase(base + slope * k + noise), (k == 0) && $urandom_range(1),
                    1'b0, none);
          sent++;
        end
      end else begin
        send_item(24'($urandom()), $urandom_range(99) < 10, 1'b0, none);
        sent++;
      end
    end
  endtask

  // Result side: random stalls, and one long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_req) begin
      out_ch.ready <= 1'b0;
      repeat (400) @(negedge clk_i);
      hold_req = 1'b0;
    end else begin
      out_ch.ready <= rx_gaps ? ($urandom_range(99) >= 38) : 1'b1;
    end
  end

  // Prediction on every accepted input item, checking on every accepted result.
  always @(posedge clk_i) begin
    disc_result_t want, got;
    if (rst_ni) begin
      quiet_cycles++;
      if (apb.psel && apb.penable) quiet_cycles = 0;
      if (in_ch.valid && in_ch.ready) begin
        want = discipline_predict(in_ch.phase_error_ps, in_ch.restart_request);
        if (typed_next) want = typed_res;
        if (in_ch.restart_request) n_restarts++;
        dac_results_q.push_back(want);
        n_items_in++;
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.dac = out_ch.dac_out;
        got.wr = out_ch.dac_write;
        got.freq = out_ch.freq_offset;
        got.cnt = out_ch.sample_count;
        quiet_cycles = 0;
        n_results++;
        if (got.wr === 1'b1) n_dac_writes++;
        if (dac_results_q.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(got.cnt), 64'd0);
        end else begin
          want = dac_results_q.pop_front();
          if (got.dac !== want.dac) report_mismatch("dac_out", 64'(got.dac), 64'(want.dac));
          if (got.wr !== want.wr) report_mismatch("dac_write", 64'(got.wr), 64'(want.wr));
          if (got.freq !== want.freq)
            report_mismatch("freq_offset", 64'(got.freq), 64'(want.freq));
          if (got.cnt !== want.cnt)
            report_mismatch("sample_count", 64'(got.cnt), 64'(want.cnt));
        end
      end
      if (quiet_cycles > 5000) begin
        $display("Timeout: no handshake for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  stim_row_t  stim_table [25];
  phase_cfg_t phase_list [7];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.phase_error_ps = '0;
    in_ch.restart_request = 1'b0;
    out_ch.ready = 1'b0;
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    apb.paddr = '0;
    apb.pwdata = '0;
    reset_window_model();

    // Directed rows: zero after reset, both phase extremes (a restart on the first), then a steep
    // ramp that reaches the first correction pair at 22 samples.
    stim_table[0] = '{24'sd0, 1'b0, 1'b1, '{14'd8192, 1'b0, 40'sd0, 16'd1}};
    stim_table[1] = '{24'sd8388607, 1'b1, 1'b1, '{14'd8192, 1'b0, 40'sd0, 16'd1}};
    stim_table[2] = '{-24'sd8388608, 1'b0, 1'b1, '{14'd8192, 1'b0, 40'sd0, 16'd2}};
    for (int k = 0; k < 22; k++) begin
      stim_table[3 + k] = '{24'(100000 * k), k == 0, 1'b0, '0};
    end

    // Register settings of the random phases, extremes and open cases among them.
    phase_list[0] = '{16'd7200, 8'd20, 30'd36600, 14'd8192, 200, 1'b0, 1'b0};
    phase_list[1] = '{16'd20, 8'd2, 30'd1, 14'd0, 250, 1'b0, 1'b0};
    phase_list[2] = '{16'd65535, 8'd255, 30'd1000000000, 14'd16383, 150, 1'b1, 1'b0};
    phase_list[3] = '{16'd0, 8'd1, 30'd0, 14'd5000, 100, 1'b0, 1'b0};
    phase_list[4] = '{16'($urandom_range(20, 300)), 8'($urandom_range(2, 30)),
                      30'($urandom_range(1000, 200000)), 14'($urandom), 300, 1'b0, 1'b0};
    phase_list[5] = '{16'd40, 8'd20, 30'd36600, 14'd8192, 300, 1'b0, 1'b1};
    phase_list[6] = '{16'($urandom_range(20, 2000)), 8'($urandom_range(2, 255)),
                      30'($urandom_range(1, 1000000000)), 14'($urandom), 250, 1'b0, 1'b0};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i]) begin
      send_item(stim_table[i].phase, stim_table[i].restart, stim_table[i].typed,
                stim_table[i].res);
    end
    drain_block();

    foreach (phase_list[p]) begin
      if (p != 0) begin
        write_register(RegWindow, 32'(phase_list[p].win));
        write_register(RegMinCnt, 32'(phase_list[p].minc));
        write_register(RegStep, 32'(phase_list[p].dstep));
        write_register(RegStart, 32'(phase_list[p].dstart));
        n_settings++;
      end
      tx_gaps = !phase_list[p].no_gaps;
      rx_gaps = !phase_list[p].no_gaps;
      if (phase_list[p].hold_off) hold_req = 1'b1;
      send_random(phase_list[p].n_items);
      drain_block();
    end

    repeat (300) @(posedge clk_i);
    $display("Covered %0d items, %0d results, %0d DAC writes, %0d restart requests",
             n_items_in, n_results, n_dac_writes, n_restarts);
    $display("over %0d register settings besides the reset defaults", n_settings);
    if (n_errors == 0 && dac_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_errors, dac_results_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
